// ===== src/wfr_pkg.sv =====
`default_nettype none

package wfr_pkg;

   localparam int STORE_DEPTH   = 4096;
   localparam int ADDR_W        = 12;
   localparam int LEN_W         = 13;
   localparam int FRAME_MAX_DEF = 4096;
   localparam int TEXT_MAX_DEF  = 2048;

   localparam logic [3:0] OP_CONT = 4'd0;
   localparam logic [3:0] OP_TEXT = 4'd1;
   localparam logic [3:0] OP_BIN  = 4'd2;
   localparam logic [3:0] OP_PING = 4'd9;
   localparam logic [3:0] OP_PONG = 4'd10;

   typedef enum logic [1:0] {
      MODE_CHUNK = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_MORE  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2,
      ST_READ  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_PASS  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

endpackage

`default_nettype wire

// ===== src/websocket_fragment_reassembler_core.sv =====
// websocket fragment reassembler
// req channel: one request per beat. tuser selects the mode (chunk beat, read a
// stored byte, clear) and flags a valid payload byte; tlast marks the last beat
// of a chunk. tdata carries the repeated chunk header, the byte and read index.
// rsp channel: one response per chunk (on its tlast beat) and per read; tuser
// holds the status, tdata the message length, binary flag and read byte.
// csr_we/csr_wdata write the binary-start enable; write it only while idle.
// throughput: one request per cycle, every mode, back to back, while req_tready
// is high. all header checks and the message state update finish in the
// accepting cycle; payload bytes go into a 4096 x 8 single-write ram with a
// registered read port. a response is registered in the ram read and the first
// response stage, then in the output register that drives rsp.
// when rsp_tready is low, the output register and one stage behind it fill;
// after that req_tready drops until the receiver takes a response.
// reset (synchronous, active high) clears the message state, the enable and
// both response stages; the ram keeps its contents, and bytes beyond the
// current message length read as zero.
`default_nettype none

module websocket_fragment_reassembler_core #(
   parameter int FRAME_MAX = wfr_pkg::FRAME_MAX_DEF,
   parameter int TEXT_MAX  = wfr_pkg::TEXT_MAX_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode, fin, frame_offset, frame_total, chunk_length, data_byte, read_index
   input  wire logic [79:0] req_tdata,
   // mode, byte_valid
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // message_length, is_binary, read_data
   output logic      [23:0] rsp_tdata,
   // status
   output logic      [1:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata
);

   localparam int BIN_CAP = (FRAME_MAX < wfr_pkg::STORE_DEPTH) ? FRAME_MAX
                                                               : wfr_pkg::STORE_DEPTH;
   localparam logic [16:0] BIN_LIMIT  = 17'(BIN_CAP);
   localparam logic [16:0] TEXT_LIMIT = 17'(TEXT_MAX);
   localparam int AW = wfr_pkg::ADDR_W;
   localparam int LW = wfr_pkg::LEN_W;

   // request fields
   wfr_pkg::mode_type req_mode;
   logic [3:0]  req_opcode;
   logic        req_fin;
   logic [15:0] req_offset;
   logic [15:0] req_total;
   logic [15:0] req_length;
   logic [7:0]  req_byte;
   logic        req_byte_valid;
   logic [AW-1:0] req_index;

   assign req_mode       = wfr_pkg::mode_type'(req_tuser[1:0]);
   assign req_byte_valid = req_tuser[2];
   assign req_opcode     = req_tdata[3:0];
   assign req_fin        = req_tdata[4];
   assign req_offset     = req_tdata[20:5];
   assign req_total      = req_tdata[36:21];
   assign req_length     = req_tdata[52:37];
   assign req_byte       = req_tdata[60:53];
   assign req_index      = req_tdata[72:61];

   // message state
   logic        allow_ff, allow_in;
   logic        poison_ff, poison_in;
   logic        active_ff, active_in;
   logic [15:0] expected_ff, expected_in;
   logic [15:0] received_ff, received_in;
   logic [3:0]  fopcode_ff, fopcode_in;
   logic        ffin_ff, ffin_in;
   logic [LW-1:0] stored_ff, stored_in;
   logic        binary_ff, binary_in;
   logic        nul_ff, nul_in;
   logic        open_ff, open_in;
   logic [15:0] count_ff, count_in;
   logic        over_ff, over_in;
   wfr_pkg::kind_type kind_ff, kind_in;
   logic [3:0]  hop_ff, hop_in;
   logic        hfin_ff, hfin_in;
   logic [15:0] hlen_ff, hlen_in;

   // response stages
   logic        s1_valid_ff, s1_valid_in;
   wfr_pkg::status_type s1_status_ff;
   logic [LW-1:0] s1_len_ff;
   logic        s1_bin_ff;
   logic        s1_rdok_ff;
   logic        out_valid_ff, out_valid_in;
   wfr_pkg::status_type out_status_ff;
   logic [LW-1:0] out_len_ff;
   logic        out_bin_ff;
   logic [7:0]  out_data_ff;

   logic        accept;
   logic        out_ready;
   logic        res_valid;
   wfr_pkg::status_type res_status;
   logic        res_rdok;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic        rd_en;
   logic [7:0]  ram_rd_data;

   logic        fail;
   logic        start;
   logic [16:0] limit;
   logic [15:0] off_frame;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;
   assign allow_in   = csr_we ? csr_wdata : allow_ff;
   assign off_frame  = req_total - req_offset;

   always_comb begin
      poison_in   = poison_ff;
      active_in   = active_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      fopcode_in  = fopcode_ff;
      ffin_in     = ffin_ff;
      stored_in   = stored_ff;
      binary_in   = binary_ff;
      nul_in      = nul_ff;
      open_in     = open_ff;
      count_in    = count_ff;
      over_in     = over_ff;
      kind_in     = kind_ff;
      hop_in      = hop_ff;
      hfin_in     = hfin_ff;
      hlen_in     = hlen_ff;
      res_valid   = 1'b0;
      res_status  = wfr_pkg::ST_MORE;
      res_rdok    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rd_en       = 1'b0;
      fail        = 1'b0;
      start       = 1'b0;
      limit       = TEXT_LIMIT;
      if (accept) begin
         unique case (req_mode)
            wfr_pkg::MODE_CLEAR: begin
               poison_in   = 1'b0;
               active_in   = 1'b0;
               expected_in = '0;
               received_in = '0;
               fopcode_in  = '0;
               ffin_in     = 1'b0;
               stored_in   = '0;
               binary_in   = 1'b0;
               nul_in      = 1'b0;
               open_in     = 1'b0;
               count_in    = '0;
               over_in     = 1'b0;
               kind_in     = wfr_pkg::KIND_DATA;
               hop_in      = '0;
               hfin_in     = 1'b0;
               hlen_in     = '0;
            end
            wfr_pkg::MODE_READ: begin
               res_valid  = 1'b1;
               res_status = wfr_pkg::ST_READ;
               rd_en      = 1'b1;
               res_rdok   = {1'b0, req_index} < stored_ff;
            end
            wfr_pkg::MODE_CHUNK: begin
               // header judged on the first beat of a chunk
               if (!open_ff) begin
                  hop_in   = req_opcode;
                  hfin_in  = req_fin;
                  hlen_in  = req_length;
                  count_in = '0;
                  over_in  = 1'b0;
                  open_in  = 1'b1;
                  kind_in  = wfr_pkg::KIND_DATA;
                  if (poison_ff) begin
                     kind_in = wfr_pkg::KIND_ERROR;
                  end else if (req_opcode == wfr_pkg::OP_PING ||
                               req_opcode == wfr_pkg::OP_PONG) begin
                     kind_in = wfr_pkg::KIND_PASS;
                  end else begin
                     if (req_offset > req_total || req_length > off_frame) begin
                        fail = 1'b1;
                     end else begin
                        if (req_offset == 16'd0) begin
                           start = req_opcode == wfr_pkg::OP_TEXT ||
                                   req_opcode == wfr_pkg::OP_BIN;
                           if (active_ff && received_ff != expected_ff) begin
                              fail = 1'b1;
                           end else if ((start && active_ff) ||
                                        (req_opcode == wfr_pkg::OP_CONT && !active_ff) ||
                                        (req_opcode != wfr_pkg::OP_CONT &&
                                         req_opcode != wfr_pkg::OP_TEXT &&
                                         !(req_opcode == wfr_pkg::OP_BIN && allow_ff))) begin
                              fail = 1'b1;
                           end else begin
                              if (start) begin
                                 stored_in = '0;
                                 binary_in = req_opcode == wfr_pkg::OP_BIN;
                                 nul_in    = 1'b0;
                                 active_in = 1'b1;
                              end
                              limit = binary_in ? BIN_LIMIT : TEXT_LIMIT;
                              if ({1'b0, req_total} + {4'b0, stored_in} > limit) begin
                                 fail = 1'b1;
                              end else begin
                                 expected_in = req_total;
                                 received_in = '0;
                                 fopcode_in  = req_opcode;
                                 ffin_in     = req_fin;
                              end
                           end
                        end
                        if (!fail && (!active_in || req_opcode != fopcode_in ||
                                      req_fin != ffin_in || req_offset != received_in ||
                                      req_total != expected_in ||
                                      {4'b0, stored_in} + {1'b0, req_length} > BIN_LIMIT)) begin
                           fail = 1'b1;
                        end
                     end
                     if (fail) begin
                        poison_in = 1'b1;
                        kind_in   = wfr_pkg::KIND_ERROR;
                     end
                  end
               end
               // payload byte
               if (kind_in == wfr_pkg::KIND_DATA && req_byte_valid) begin
                  if (count_in < hlen_in) begin
                     wr_en   = 1'b1;
                     wr_addr = stored_in[AW-1:0] + count_in[AW-1:0];
                     if (!binary_in && req_byte == 8'd0) begin
                        nul_in = 1'b1;
                     end
                     count_in = count_in + 16'd1;
                  end else begin
                     over_in = 1'b1;
                  end
               end
               // verdict on the last beat
               if (req_tlast) begin
                  res_valid = 1'b1;
                  open_in   = 1'b0;
                  case (kind_in)
                     wfr_pkg::KIND_ERROR: res_status = wfr_pkg::ST_ERROR;
                     wfr_pkg::KIND_PASS:  res_status = wfr_pkg::ST_MORE;
                     wfr_pkg::KIND_DATA: begin
                        if (over_in || count_in != hlen_in) begin
                           poison_in  = 1'b1;
                           res_status = wfr_pkg::ST_ERROR;
                        end else begin
                           stored_in   = stored_in + hlen_in[LW-1:0];
                           received_in = received_in + hlen_in;
                           if (received_in == expected_in && hfin_in) begin
                              if (!binary_in && nul_in) begin
                                 poison_in  = 1'b1;
                                 res_status = wfr_pkg::ST_ERROR;
                              end else begin
                                 active_in  = 1'b0;
                                 res_status = wfr_pkg::ST_DONE;
                              end
                           end else begin
                              res_status = wfr_pkg::ST_MORE;
                           end
                        end
                     end
                     default: res_status = wfr_pkg::ST_ERROR;
                  endcase
               end
            end
            wfr_pkg::MODE_NONE: begin
               res_valid = 1'b0;
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = res_valid;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff     <= 1'b0;
         poison_ff    <= 1'b0;
         active_ff    <= 1'b0;
         expected_ff  <= '0;
         received_ff  <= '0;
         fopcode_ff   <= '0;
         ffin_ff      <= 1'b0;
         stored_ff    <= '0;
         binary_ff    <= 1'b0;
         nul_ff       <= 1'b0;
         open_ff      <= 1'b0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         kind_ff      <= wfr_pkg::KIND_DATA;
         hop_ff       <= '0;
         hfin_ff      <= 1'b0;
         hlen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         allow_ff     <= allow_in;
         poison_ff    <= poison_in;
         active_ff    <= active_in;
         expected_ff  <= expected_in;
         received_ff  <= received_in;
         fopcode_ff   <= fopcode_in;
         ffin_ff      <= ffin_in;
         stored_ff    <= stored_in;
         binary_ff    <= binary_in;
         nul_ff       <= nul_in;
         open_ff      <= open_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         kind_ff      <= kind_in;
         hop_ff       <= hop_in;
         hfin_ff      <= hfin_in;
         hlen_ff      <= hlen_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= res_status;
         s1_len_ff    <= stored_in;
         s1_bin_ff    <= binary_in;
         s1_rdok_ff   <= res_rdok;
      end
      if (out_ready) begin
         out_status_ff <= s1_status_ff;
         out_len_ff    <= s1_len_ff;
         out_bin_ff    <= s1_bin_ff;
         out_data_ff   <= s1_rdok_ff ? ram_rd_data : 8'd0;
      end
   end

   wfr_ram #(
      .WIDTH (8),
      .DEPTH (wfr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_en   (rd_en),
      .rd_addr (req_index),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {2'b00, out_data_ff, out_bin_ff, out_len_ff};

endmodule

`default_nettype wire

// ===== src/wfr_ram.sv =====
`default_nettype none

module wfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/wfr_checker.sv =====
`default_nettype none

module wfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // reset empties the response stages
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // chunk responses carry no read byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != wfr_pkg::ST_READ |-> rsp_tdata[21:14] == 8'd0)
      else $error("read byte on chunk response");

   // an empty message reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wfr_pkg::ST_READ && rsp_tdata[12:0] == 13'd0
      |-> rsp_tdata[21:14] == 8'd0)
      else $error("read of empty message returned data");

   // the message never outgrows the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:0] <= 13'(wfr_pkg::STORE_DEPTH))
      else $error("message length beyond store");

endmodule

bind websocket_fragment_reassembler_core wfr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
